FILE: rtl/core/tlrr_pkg.sv
// ----------------------------------------------------------------------------
// tlrr_pkg: shared definitions for the two-level round-robin arbiter
// Field widths, stream packing and default sizes used by the arbiter and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tlrr_pkg;

  // Default sizes
  localparam int unsigned SLICES_DEF = 2;
  localparam int unsigned PORTS_DEF  = 32;

  // Item field widths
  localparam int unsigned SLICE_FIELD_W = 1;
  localparam int unsigned PORT_FIELD_W  = 5;
  localparam int unsigned GPORT_FIELD_W = 6;

  // Stream packing: input tdata = {pad, local_port, slice_index}
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_SLICE_LSB = 0;
  localparam int unsigned IN_PORT_LSB  = IN_SLICE_LSB + SLICE_FIELD_W;

  // Output tdata = {pad, requests_remain, granted_port, granted_slice, grant_found}
  localparam int unsigned OUT_DATA_W     = 16;
  localparam int unsigned OUT_FOUND_BIT  = 0;
  localparam int unsigned OUT_SLICE_BIT  = 1;
  localparam int unsigned OUT_GPORT_LSB  = 2;
  localparam int unsigned OUT_REMAIN_BIT = OUT_GPORT_LSB + GPORT_FIELD_W;

  // Item kind carried in tuser
  typedef enum logic {
    ACT_REQUEST   = 1'b0,
    ACT_ARBITRATE = 1'b1
  } action_e;

  // Registered input item
  typedef struct packed {
    action_e                  action;
    logic [SLICE_FIELD_W-1:0] slice_index;
    logic [PORT_FIELD_W-1:0]  local_port;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic                     requests_remain;
    logic [GPORT_FIELD_W-1:0] granted_port;
    logic [SLICE_FIELD_W-1:0] granted_slice;
    logic                     grant_found;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/tlrr_pick.sv
// ----------------------------------------------------------------------------
// tlrr_pick: round-robin picker
// Finds the first set request bit after a pointer, wrapping around.
// ----------------------------------------------------------------------------
`default_nettype none

module tlrr_pick #(
  parameter int unsigned N = 2
) (
  input  logic [N-1:0]                  req_i,
  input  logic [(N > 1 ? $clog2(N) : 1)-1:0] ptr_i,
  output logic                          found_o,
  output logic [(N > 1 ? $clog2(N) : 1)-1:0] idx_o
);

  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]  upper;
  logic [N-1:0]  masked;
  logic [IW-1:0] idx_hi;
  logic [IW-1:0] idx_lo;

  // Mark requests strictly above the pointer
  always_comb begin
    for (int unsigned i = 0; i < N; i++) begin
      upper[i] = (IW'(i) > ptr_i);
    end
    masked = req_i & upper;
  end

  // Lowest set bit of both the masked and the full vector
  always_comb begin
    idx_hi = '0;
    idx_lo = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (masked[i]) begin
        idx_hi = IW'(i);
      end
      if (req_i[i]) begin
        idx_lo = IW'(i);
      end
    end
  end

  // Prefer the wrap-free hit, else wrap to the lowest request
  assign found_o = |req_i;
  assign idx_o   = (|masked) ? idx_hi : idx_lo;

endmodule

`default_nettype wire

FILE: rtl/core/two_level_round_robin_arbiter.sv
// ----------------------------------------------------------------------------
// two_level_round_robin_arbiter: slice-then-port round-robin arbiter
// Holds pending request bits per slice and port and grants at most one per arbitrate item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser = 0 posts a request for (slice_index,
//   local_port), tuser = 1 arbitrates once. A request item makes no result;
//   an arbitrate item makes exactly one result on m_axis.
//   An accepted item is held in an input register and resolved, once it can
//   retire, against the request bits and pointers, which update at the edge
//   that ends that cycle; its result is loaded into the output register at
//   that same edge, which raises m_axis_tvalid_o.
//   One item per cycle is sustained unless an arbitrate item waits on a
//   stalled result: the slice pick and port pick are single-pass priority
//   encoders, and each item sees the state left by the one before it.
//   If m_axis stalls, a result waits in the output register; request items
//   keep flowing, and the next arbitrate item waits in the input register,
//   which drops s_axis_tready_o until the result is taken.
//   Reset clears all request bits, points the slice pointer at the last
//   slice and each port pointer at the last port, and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_round_robin_arbiter #(
  parameter int unsigned SLICES = tlrr_pkg::SLICES_DEF,
  parameter int unsigned PORTS  = tlrr_pkg::PORTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: [0] slice_index, [5:1] local_port, [7:6] zero
  input  logic [tlrr_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tuser: [0] action
  input  logic                             s_axis_tuser_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: [0] grant_found, [1] granted_slice, [7:2] granted_port,
  //        [8] requests_remain, [15:9] zero
  output logic [tlrr_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i
);

  import tlrr_pkg::*;

  localparam int unsigned SW = (SLICES > 1) ? $clog2(SLICES) : 1;
  localparam int unsigned PW = (PORTS > 1) ? $clog2(PORTS) : 1;

  // Input register
  logic     in_valid_q;
  in_item_t in_item_q;

  // Result register
  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  // Arbitration state
  logic [PORTS-1:0] req_q [SLICES];
  logic [PORTS-1:0] req_d [SLICES];
  logic [SW-1:0]    last_slice_q, last_slice_d;
  logic [PW-1:0]    port_ptr_q [SLICES];
  logic [PW-1:0]    port_ptr_d [SLICES];

  // Picker wires
  logic [SLICES-1:0] slice_any;
  logic              slice_found;
  logic [SW-1:0]     sel_slice;
  logic              port_found;
  logic [PW-1:0]     sel_port;

  logic out_free;
  logic proc;
  logic is_arb;
  logic req_ok;
  logic any_left;

  // Handshake: advance the input register when its item can retire
  assign is_arb          = (in_item_q.action == ACT_ARBITRATE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign proc            = in_valid_q && (!is_arb || out_free);
  assign s_axis_tready_o = !in_valid_q || proc;

  // Capture an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.action      <= action_e'(s_axis_tuser_i);
      in_item_q.slice_index <= s_axis_tdata_i[IN_SLICE_LSB +: SLICE_FIELD_W];
      in_item_q.local_port  <= s_axis_tdata_i[IN_PORT_LSB +: PORT_FIELD_W];
    end
  end

  // Slice level: any pending request per slice
  always_comb begin
    for (int unsigned s = 0; s < SLICES; s++) begin
      slice_any[s] = |req_q[s];
    end
  end

  tlrr_pick #(.N(SLICES)) u_slice_pick (
    .req_i   (slice_any),
    .ptr_i   (last_slice_q),
    .found_o (slice_found),
    .idx_o   (sel_slice)
  );

  // Port level within the chosen slice
  tlrr_pick #(.N(PORTS)) u_port_pick (
    .req_i   (req_q[sel_slice]),
    .ptr_i   (port_ptr_q[sel_slice]),
    .found_o (port_found),
    .idx_o   (sel_port)
  );

  // Range check for a posted request
  assign req_ok = (32'(in_item_q.slice_index) < SLICES) &&
                  (32'(in_item_q.local_port) < PORTS);

  // Next state: set a posted bit, or clear the granted one and move the pointers to it
  always_comb begin
    last_slice_d = last_slice_q;
    for (int unsigned s = 0; s < SLICES; s++) begin
      req_d[s]      = req_q[s];
      port_ptr_d[s] = port_ptr_q[s];
      for (int unsigned p = 0; p < PORTS; p++) begin
        if (proc && !is_arb && req_ok &&
            (32'(in_item_q.slice_index) == s) && (32'(in_item_q.local_port) == p)) begin
          req_d[s][p] = 1'b1;
        end
        if (proc && is_arb && slice_found && port_found &&
            (sel_slice == SW'(s)) && (sel_port == PW'(p))) begin
          req_d[s][p] = 1'b0;
        end
      end
      if (proc && is_arb && slice_found && port_found && (sel_slice == SW'(s))) begin
        port_ptr_d[s] = sel_port;
      end
    end
    if (proc && is_arb && slice_found && port_found) begin
      last_slice_d = sel_slice;
    end
  end

  // Pending requests after this item
  always_comb begin
    any_left = 1'b0;
    for (int unsigned s = 0; s < SLICES; s++) begin
      any_left = any_left | (|req_d[s]);
    end
  end

  // Result of an arbitrate item
  always_comb begin
    out_item_d                 = '0;
    out_item_d.requests_remain = any_left;
    if (slice_found && port_found) begin
      out_item_d.grant_found   = 1'b1;
      out_item_d.granted_slice = SLICE_FIELD_W'(sel_slice);
      out_item_d.granted_port  = GPORT_FIELD_W'(32'(sel_slice) * PORTS + 32'(sel_port));
    end
  end

  // Hold arbitration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_slice_q <= SW'(SLICES - 1);
      for (int unsigned s = 0; s < SLICES; s++) begin
        req_q[s]      <= '0;
        port_ptr_q[s] <= PW'(PORTS - 1);
      end
    end else begin
      last_slice_q <= last_slice_d;
      for (int unsigned s = 0; s < SLICES; s++) begin
        req_q[s]      <= req_d[s];
        port_ptr_q[s] <= port_ptr_d[s];
      end
    end
  end

  // Result register: load on an arbitrate item, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && is_arb) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && is_arb) begin
      out_item_q <= out_item_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - OUT_REMAIN_BIT - 1){1'b0}},
                            out_item_q.requests_remain,
                            out_item_q.granted_port,
                            out_item_q.granted_slice,
                            out_item_q.grant_found};

endmodule

`default_nettype wire

FILE: rtl/core/tlrr_checker.sv
// ----------------------------------------------------------------------------
// tlrr_checker: port-level checks for the two-level round-robin arbiter
// Watches the output stream port over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlrr_checker #(
  parameter int unsigned SLICES = tlrr_pkg::SLICES_DEF,
  parameter int unsigned PORTS  = tlrr_pkg::PORTS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic [tlrr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i
);

  import tlrr_pkg::*;

  logic                     found;
  logic                     remain;
  logic                     gslice;
  logic [GPORT_FIELD_W-1:0] gport;

  assign found  = m_axis_tdata_o[OUT_FOUND_BIT];
  assign remain = m_axis_tdata_o[OUT_REMAIN_BIT];
  assign gslice = m_axis_tdata_o[OUT_SLICE_BIT];
  assign gport  = m_axis_tdata_o[OUT_GPORT_LSB +: GPORT_FIELD_W];

  // No result is offered while reset is applied
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result offered during reset");

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // No grant means nothing was pending, so every field is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !found |-> !remain && !gslice && (gport == '0))
    else $error("empty result carries nonzero fields");

  // A granted port lies inside the configured range, checked when that range is below 64
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && found && (SLICES * PORTS < 64) |->
      (32'(gport) < SLICES * PORTS))
    else $error("granted port out of range");

endmodule

bind two_level_round_robin_arbiter tlrr_checker #(
  .SLICES (SLICES),
  .PORTS  (PORTS)
) u_tlrr_checker (.*);

`default_nettype wire
